/* design/tcpft_pkg.sv */
// ----------------------------------------------------------------------------
// tcpft_pkg: shared types and codes of the TCP flow state tracker
// Packet summary, result record, stored flow entry and the code points used
// for outcome, direction and connection state.
// ----------------------------------------------------------------------------
package tcpft_pkg;

  localparam logic [15:0] IdleTimeoutReset = 16'd60;

  // outcome codes
  localparam logic [1:0] OC_NEW     = 2'd0;
  localparam logic [1:0] OC_UPDATE  = 2'd1;
  localparam logic [1:0] OC_UNKNOWN = 2'd2;
  localparam logic [1:0] OC_FULL    = 2'd3;

  // direction codes
  localparam logic [1:0] DIR_C2S     = 2'd0;
  localparam logic [1:0] DIR_S2C     = 2'd1;
  localparam logic [1:0] DIR_UNKNOWN = 2'd2;

  // connection states
  localparam logic [2:0] ST_SYN    = 3'd0;
  localparam logic [2:0] ST_SYNACK = 3'd1;
  localparam logic [2:0] ST_EST    = 3'd2;
  localparam logic [2:0] ST_FIN1   = 3'd3;
  localparam logic [2:0] ST_FIN2   = 3'd4;
  localparam logic [2:0] ST_CLOSED = 3'd5;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_fin;
    logic        flag_rst;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  direction;
    logic [2:0]  flow_state;
    logic [31:0] seq_offset;
    logic [31:0] ack_offset;
    logic [6:0]  flows_freed;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [31:0] client_addr;
    logic [31:0] server_addr;
    logic [15:0] client_port;
    logic [15:0] server_port;
    logic [31:0] client_isn;
    logic [31:0] server_isn;
    logic [31:0] last_update;
  } entry_t;

endpackage

/* design/tcp_flow_state_tracker_top.sv */
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker_top: connection tracking table for TCP packets
// A SYN scans the valid bits for a free slot; other packets walk the flows in
// creation order through an order list, compacting it as entries are freed.
// A SYN takes the lowest free slot; a full table answers it without a scan.
// The walk visits each live flow through S_ORD, S_ENT and S_EVAL in turn.
// Throughput: one packet at a time; in_stall_o is high until the result is taken.
// The walk reads one order-list entry and one flow entry per visited flow.
// Reset: valid bits and live count clear at once, no clearing pass; timeout 60.
// ----------------------------------------------------------------------------
module tcp_flow_state_tracker_top #(
  parameter int FLOW_ENTRIES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tcpft_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcpft_pkg::out_item_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i
);
  import tcpft_pkg::*;

  localparam int SW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int RW = $clog2(FLOW_ENTRIES + 1);
  localparam logic [RW-1:0] Full = RW'(FLOW_ENTRIES);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_ORD  = 6'b000100,
    S_ENT  = 6'b001000,
    S_EVAL = 6'b010000,
    S_OUT  = 6'b100000
  } fsm_e;

  fsm_e fsm_q, fsm_d;
  in_item_t pkt_q;
  out_item_t res_q, res_d;
  logic [15:0] tmo_q;
  logic [FLOW_ENTRIES-1:0] valid_q, valid_d;
  logic [RW-1:0] cnt_q, cnt_d, r_q, r_d, w_q, w_d;
  logic [SW-1:0] idx_q, idx_d, slot_q, slot_d;
  logic [6:0] freed_q, freed_d;
  logic took_q, took_d;

  // memories
  entry_t ent_mem [FLOW_ENTRIES];
  logic [SW-1:0] ord_mem [FLOW_ENTRIES];
  entry_t ent_rd_q;
  logic [SW-1:0] ord_rd_q;
  logic ent_we, ent_re, ord_we, ord_re;
  logic [SW-1:0] ent_wa, ord_wa;
  logic [RW-1:0] ord_wr;
  entry_t ent_wd;
  logic [SW-1:0] ord_wd;

  // walk decision
  entry_t upd;
  logic fwd, rev, take, expire;
  logic [32:0] deadline;

  assign in_stall_o  = (fsm_q != S_IDLE);
  assign out_valid_o = (fsm_q == S_OUT);
  assign out_data_o  = res_q;
  assign cfg_ready_o = 1'b1;
  assign ord_wa = ord_wr[SW-1:0];

  // match and state transition for the entry under the walk
  always_comb begin
    upd  = ent_rd_q;
    take = 1'b0;
    fwd = (pkt_q.dst_port == ent_rd_q.server_port) && (pkt_q.dst_addr == ent_rd_q.server_addr)
       && (pkt_q.src_addr == ent_rd_q.client_addr) && (pkt_q.src_port == ent_rd_q.client_port);
    rev = (pkt_q.dst_port == ent_rd_q.client_port) && (pkt_q.dst_addr == ent_rd_q.client_addr)
       && (pkt_q.src_addr == ent_rd_q.server_addr) && (pkt_q.src_port == ent_rd_q.server_port);
    if (fwd) begin
      if (pkt_q.flag_fin && !pkt_q.flag_ack) begin
        if (ent_rd_q.state == ST_EST) begin
          upd.state = ST_FIN1;
          take = 1'b1;
        end
      end else if (pkt_q.flag_fin && pkt_q.flag_ack) begin
        if (ent_rd_q.state == ST_EST) begin
          upd.state = ST_FIN2;
          take = 1'b1;
        end
      end else if (pkt_q.flag_ack) begin
        if (ent_rd_q.state == ST_FIN1 || ent_rd_q.state == ST_FIN2) begin
          upd.state = ST_CLOSED;
          take = 1'b1;
        end else if (ent_rd_q.state == ST_SYNACK || ent_rd_q.state == ST_EST) begin
          upd.state = ST_EST;
          take = 1'b1;
        end
      end else if (pkt_q.flag_rst) begin
        upd.state = ST_CLOSED;
        take = 1'b1;
      end
    end else if (rev) begin
      if (pkt_q.flag_syn && pkt_q.flag_ack) begin
        if (ent_rd_q.state == ST_SYN) begin
          upd.server_isn = pkt_q.seq_number;
          upd.state = ST_SYNACK;
          take = 1'b1;
        end
      end else if (pkt_q.flag_fin && pkt_q.flag_ack) begin
        if (ent_rd_q.state == ST_FIN1) begin
          upd.state = ST_FIN2;
          take = 1'b1;
        end
      end else if (pkt_q.flag_ack) begin
        if (ent_rd_q.state == ST_EST) take = 1'b1;
      end else if (pkt_q.flag_rst) begin
        upd.state = ST_CLOSED;
        take = 1'b1;
      end
    end
    // A RST without ACK, FIN or (from the server) SYN leaves the timestamp alone
    if (take && !(pkt_q.flag_rst && !pkt_q.flag_ack && !pkt_q.flag_fin
                  && !(pkt_q.flag_syn && rev))) begin
      upd.last_update = pkt_q.now_seconds;
    end
    deadline = {1'b0, ent_rd_q.last_update} + {17'd0, tmo_q};
    expire = (deadline < {1'b0, pkt_q.now_seconds}) || (ent_rd_q.state == ST_CLOSED);
  end

  // sequencer
  always_comb begin
    fsm_d = fsm_q; res_d = res_q; valid_d = valid_q; cnt_d = cnt_q;
    r_d = r_q; w_d = w_q; idx_d = idx_q; slot_d = slot_q;
    freed_d = freed_q; took_d = took_q;
    ent_we = 1'b0; ent_re = 1'b0; ord_we = 1'b0; ord_re = 1'b0;
    ent_wa = slot_q; ent_wd = upd; ord_wr = w_q; ord_wd = slot_q;
    case (fsm_q)
      S_IDLE: begin
        if (in_valid_i) begin
          r_d = '0; w_d = '0; idx_d = '0; freed_d = '0; took_d = 1'b0;
          res_d = '{OC_UNKNOWN, DIR_UNKNOWN, ST_SYN, 32'd0, 32'd0, 7'd0};
          if (in_data_i.flag_syn && !in_data_i.flag_ack) begin
            if (cnt_q == Full) begin
              res_d.outcome = OC_FULL;
              fsm_d = S_OUT;
            end else begin
              fsm_d = S_SCAN;
            end
          end else begin
            fsm_d = S_ORD;
          end
        end
      end
      S_SCAN: begin
        // open the flow in the lowest free slot
        if (!valid_q[idx_q]) begin
          ent_we = 1'b1; ent_wa = idx_q;
          ent_wd = '{ST_SYN, pkt_q.src_addr, pkt_q.dst_addr, pkt_q.src_port,
                     pkt_q.dst_port, pkt_q.seq_number, 32'd0, pkt_q.now_seconds};
          ord_we = 1'b1; ord_wr = cnt_q; ord_wd = idx_q;
          valid_d[idx_q] = 1'b1;
          cnt_d = cnt_q + 1'b1;
          res_d = '{OC_NEW, DIR_C2S, ST_SYN, 32'd0, pkt_q.ack_number, 7'd0};
          fsm_d = S_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_ORD: begin
        if (r_q == cnt_q) begin
          cnt_d = w_q;
          if (!took_q) res_d.flows_freed = freed_q;
          fsm_d = S_OUT;
        end else begin
          ord_re = 1'b1;
          fsm_d = S_ENT;
        end
      end
      S_ENT: begin
        ent_re = 1'b1;
        slot_d = ord_rd_q;
        fsm_d = S_EVAL;
      end
      S_EVAL: begin
        r_d = r_q + 1'b1;
        fsm_d = S_ORD;
        if (took_q) begin
          // compact the rest of the order list
          ord_we = 1'b1;
          w_d = w_q + 1'b1;
        end else if (take) begin
          ent_we = 1'b1;
          ord_we = 1'b1;
          w_d = w_q + 1'b1;
          took_d = 1'b1;
          res_d.outcome = OC_UPDATE;
          res_d.flow_state = upd.state;
          res_d.flows_freed = freed_q;
          if (fwd) begin
            res_d.direction = DIR_C2S;
            res_d.seq_offset = pkt_q.seq_number - upd.client_isn;
            res_d.ack_offset = pkt_q.ack_number - upd.server_isn;
          end else begin
            res_d.direction = DIR_S2C;
            res_d.seq_offset = pkt_q.seq_number - upd.server_isn;
            res_d.ack_offset = pkt_q.ack_number - upd.client_isn;
          end
        end else if (expire) begin
          // drop the passed flow
          valid_d[slot_q] = 1'b0;
          freed_d = freed_q + 1'b1;
        end else begin
          ord_we = 1'b1;
          w_d = w_q + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_stall_i) fsm_d = S_IDLE;
      end
      default: fsm_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= S_IDLE; valid_q <= '0; cnt_q <= '0; tmo_q <= IdleTimeoutReset;
      r_q <= '0; w_q <= '0; idx_q <= '0; freed_q <= '0; took_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d; valid_q <= valid_d; cnt_q <= cnt_d;
      r_q <= r_d; w_q <= w_d; idx_q <= idx_d; freed_q <= freed_d; took_q <= took_d;
      if (cfg_valid_i) tmo_q <= cfg_data_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (fsm_q == S_IDLE && in_valid_i) pkt_q <= in_data_i;
    res_q <= res_d;
    slot_q <= slot_d;
  end

  // flow entry memory
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_rd_q <= ent_mem[ord_rd_q];
  end

  // creation order list
  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_rd_q <= ord_mem[r_q[SW-1:0]];
  end

endmodule
